// ===== src/ldsp_pkg.sv =====
// Package for the lax DER signature parser.
// Holds the parse phase and status codes, size constants and the
// control struct shared by the parser modules. No dependencies.
package ldsp_pkg;

  localparam int MAX_SIG_BYTES_DEF = 1024;
  localparam int INT_BYTES         = 32;
  localparam int VAL_W             = 8 * INT_BYTES;
  localparam int CNT_W             = $clog2(INT_BYTES + 2);
  localparam int WORD_W            = 64;

  localparam logic [7:0] TAG_SEQ  = 8'h30;
  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] LEN_LONG = 8'h80;

  typedef enum logic [11:0] {
    PH_SEQ_TAG  = 12'b0000_0000_0001,
    PH_SEQ_LEN  = 12'b0000_0000_0010,
    PH_SEQ_SKIP = 12'b0000_0000_0100,
    PH_R_TAG    = 12'b0000_0000_1000,
    PH_R_LEN    = 12'b0000_0001_0000,
    PH_R_LONG   = 12'b0000_0010_0000,
    PH_R_BODY   = 12'b0000_0100_0000,
    PH_S_TAG    = 12'b0000_1000_0000,
    PH_S_LEN    = 12'b0001_0000_0000,
    PH_S_LONG   = 12'b0010_0000_0000,
    PH_S_BODY   = 12'b0100_0000_0000,
    PH_DONE     = 12'b1000_0000_0000
  } ldsp_phase_t;

  typedef enum logic [1:0] {
    ST_REJECT   = 2'd0,
    ST_OK       = 2'd1,
    ST_OVERFLOW = 2'd2
  } ldsp_status_t;

  // Per-byte decisions from the parse control to the value registers and the result status.
  typedef struct packed {
    logic r_sig;    // significant byte of R
    logic s_sig;    // significant byte of S
    logic done_ok;  // parse complete and not rejected after this byte
  } ldsp_ctl_t;

endpackage

// ===== src/ldsp_ctrl.sv =====
// Parse control for the lax DER signature parser: phase state machine,
// length counters and zero stripping. Depends on ldsp_pkg.
module ldsp_ctrl #(
  parameter int MAX_SIG_BYTES = ldsp_pkg::MAX_SIG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        sig_byte,
  input  logic              last,
  output ldsp_pkg::ldsp_ctl_t ctl
);

  localparam int LW = $clog2(MAX_SIG_BYTES + 2);
  localparam logic [LW+7:0] LEN_MAX = (LW+8)'(MAX_SIG_BYTES);
  localparam logic [LW+7:0] LEN_SAT = (LW+8)'(MAX_SIG_BYTES + 1);

  ldsp_pkg::ldsp_phase_t phase_r, phase_nxt;
  logic [6:0]    skip_r, skip_nxt;
  logic [6:0]    lbl_r, lbl_nxt;
  logic [3:0]    lsig_r, lsig_nxt;
  logic [LW-1:0] accum_r, accum_nxt;
  logic [LW-1:0] content_r, content_nxt;
  logic          strip_r, strip_nxt;
  logic          rej_r, rej_nxt;

  logic          sig;
  logic          is_r;
  logic          do_fin;
  logic [LW+7:0] fin_len;
  logic [LW+7:0] acc_calc;

  assign sig      = !(strip_r && (sig_byte == 8'd0));
  assign acc_calc = {accum_r, 8'd0} + {{LW{1'b0}}, sig_byte};

  always_comb begin
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    lbl_nxt     = lbl_r;
    lsig_nxt    = lsig_r;
    accum_nxt   = accum_r;
    content_nxt = content_r;
    strip_nxt   = strip_r;
    rej_nxt     = rej_r;
    do_fin      = 1'b0;
    fin_len     = '0;
    is_r        = (phase_r == ldsp_pkg::PH_R_LEN) || (phase_r == ldsp_pkg::PH_R_LONG);
    ctl.r_sig   = 1'b0;
    ctl.s_sig   = 1'b0;
    if (!rej_r) begin
      case (phase_r)
        ldsp_pkg::PH_SEQ_TAG: begin
          if (sig_byte == ldsp_pkg::TAG_SEQ) phase_nxt = ldsp_pkg::PH_SEQ_LEN;
          else rej_nxt = 1'b1;
        end
        ldsp_pkg::PH_SEQ_LEN: begin
          if ((sig_byte & ldsp_pkg::LEN_LONG) != 8'd0 && sig_byte[6:0] != 7'd0) begin
            skip_nxt  = sig_byte[6:0];
            phase_nxt = ldsp_pkg::PH_SEQ_SKIP;
          end else begin
            phase_nxt = ldsp_pkg::PH_R_TAG;
          end
        end
        ldsp_pkg::PH_SEQ_SKIP: begin
          skip_nxt = skip_r - 7'd1;
          if (skip_r == 7'd1) phase_nxt = ldsp_pkg::PH_R_TAG;
        end
        ldsp_pkg::PH_R_TAG: begin
          if (sig_byte == ldsp_pkg::TAG_INT) phase_nxt = ldsp_pkg::PH_R_LEN;
          else rej_nxt = 1'b1;
        end
        ldsp_pkg::PH_S_TAG: begin
          if (sig_byte == ldsp_pkg::TAG_INT) phase_nxt = ldsp_pkg::PH_S_LEN;
          else rej_nxt = 1'b1;
        end
        ldsp_pkg::PH_R_LEN, ldsp_pkg::PH_S_LEN: begin
          if ((sig_byte & ldsp_pkg::LEN_LONG) == 8'd0 || sig_byte[6:0] == 7'd0) begin
            do_fin  = 1'b1;
            fin_len = ((sig_byte & ldsp_pkg::LEN_LONG) == 8'd0) ?
                      {{LW{1'b0}}, sig_byte} : '0;
          end else begin
            lbl_nxt   = sig_byte[6:0];
            lsig_nxt  = 4'd0;
            accum_nxt = '0;
            strip_nxt = 1'b1;
            phase_nxt = is_r ? ldsp_pkg::PH_R_LONG : ldsp_pkg::PH_S_LONG;
          end
        end
        ldsp_pkg::PH_R_LONG, ldsp_pkg::PH_S_LONG: begin
          if (sig && lsig_r >= 4'd7) begin
            // The eighth significant length byte rejects before counting down.
            strip_nxt = 1'b0;
            lsig_nxt  = 4'd8;
            rej_nxt   = 1'b1;
          end else begin
            if (sig) begin
              strip_nxt = 1'b0;
              lsig_nxt  = lsig_r + 4'd1;
              accum_nxt = (acc_calc > LEN_SAT) ? LEN_SAT[LW-1:0] : acc_calc[LW-1:0];
            end
            lbl_nxt = lbl_r - 7'd1;
            if (lbl_r == 7'd1) begin
              do_fin  = 1'b1;
              fin_len = {8'd0, accum_nxt};
            end
          end
        end
        ldsp_pkg::PH_R_BODY, ldsp_pkg::PH_S_BODY: begin
          if (sig) strip_nxt = 1'b0;
          ctl.r_sig   = sig && (phase_r == ldsp_pkg::PH_R_BODY);
          ctl.s_sig   = sig && (phase_r == ldsp_pkg::PH_S_BODY);
          content_nxt = content_r - {{(LW-1){1'b0}}, 1'b1};
          if (content_r == {{(LW-1){1'b0}}, 1'b1}) begin
            phase_nxt = (phase_r == ldsp_pkg::PH_R_BODY) ? ldsp_pkg::PH_S_TAG :
                        ldsp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
      if (do_fin) begin
        if (fin_len > LEN_MAX) begin
          rej_nxt = 1'b1;
        end else begin
          content_nxt = fin_len[LW-1:0];
          strip_nxt   = 1'b1;
          if (fin_len != '0) begin
            phase_nxt = is_r ? ldsp_pkg::PH_R_BODY : ldsp_pkg::PH_S_BODY;
          end else begin
            phase_nxt = is_r ? ldsp_pkg::PH_S_TAG : ldsp_pkg::PH_DONE;
          end
        end
      end
    end
    ctl.done_ok = !rej_nxt && (phase_nxt == ldsp_pkg::PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (en && last)) begin
      phase_r   <= ldsp_pkg::PH_SEQ_TAG;
      skip_r    <= '0;
      lbl_r     <= '0;
      lsig_r    <= '0;
      accum_r   <= '0;
      content_r <= '0;
      strip_r   <= 1'b1;
      rej_r     <= 1'b0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
      lbl_r     <= lbl_nxt;
      lsig_r    <= lsig_nxt;
      accum_r   <= accum_nxt;
      content_r <= content_nxt;
      strip_r   <= strip_nxt;
      rej_r     <= rej_nxt;
    end
  end

endmodule

// ===== src/ldsp_value.sv =====
// One 256-bit integer register for R or S with its significant-byte count.
// Bytes shift in from the right; the count saturates one past full.
// Depends on ldsp_pkg.
module ldsp_value (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        last,
  input  logic                        sig,
  input  logic [7:0]                  sig_byte,
  output logic [ldsp_pkg::VAL_W-1:0]  val_nxt,
  output logic                        ovf_nxt
);

  localparam logic [ldsp_pkg::CNT_W-1:0] FULL = ldsp_pkg::CNT_W'(ldsp_pkg::INT_BYTES);

  logic [ldsp_pkg::VAL_W-1:0] val_r;
  logic [ldsp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    val_nxt = val_r;
    cnt_nxt = cnt_r;
    if (sig && cnt_r <= FULL) begin
      cnt_nxt = cnt_r + {{(ldsp_pkg::CNT_W-1){1'b0}}, 1'b1};
      if (cnt_r < FULL) val_nxt = {val_r[ldsp_pkg::VAL_W-9:0], sig_byte};
    end
  end

  assign ovf_nxt = cnt_nxt > FULL;

  always_ff @(posedge clk) begin
    if (!rst_n || (en && last)) begin
      val_r <= '0;
      cnt_r <= '0;
    end else if (en) begin
      val_r <= val_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/lax_der_signature_parser_unit.sv =====
// Top level of the lax DER signature parser: input register, parse control,
// R and S value registers and the result register.
// Depends on ldsp_pkg, ldsp_ctrl and ldsp_value.
//
// Usage: feed the DER-encoded signature one byte per request on the in_
// channel, with in_last high on its final byte. Each signature yields exactly
// one result request on the out_ channel, carrying out_status and R and S as
// four 64-bit words each, most significant word first. Bytes before in_last
// produce no result. Trailing bytes after S are ignored.
// Throughput: one byte per cycle while no last byte waits on a held result,
// set by the parse-state update between the input register and the result register.
// The last byte is held in the input register, and its result in the result register.
// A new signature may start on the cycle after the previous last byte.
// When out_stall holds a result, the next signature's bytes keep flowing
// until its own last byte reaches the input register; that byte then waits
// and in_stall rises until the result is taken.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to expect a sequence tag; no clearing pass is needed.
module lax_der_signature_parser_unit #(
  parameter int MAX_SIG_BYTES = ldsp_pkg::MAX_SIG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_sig_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_r_word3,
  output logic [63:0] out_r_word2,
  output logic [63:0] out_r_word1,
  output logic [63:0] out_r_word0,
  output logic [63:0] out_s_word3,
  output logic [63:0] out_s_word2,
  output logic [63:0] out_s_word1,
  output logic [63:0] out_s_word0
);

  logic                       in_v_r;
  logic [7:0]                 byte_r;
  logic                       last_r;
  logic                       proc;
  logic                       load_out;
  logic                       accept;
  ldsp_pkg::ldsp_ctl_t        ctl;
  logic [ldsp_pkg::VAL_W-1:0] r_nxt, s_nxt;
  logic                       r_ovf, s_ovf;
  ldsp_pkg::ldsp_status_t     status_nxt;
  logic                       out_v_r;
  logic [1:0]                 status_r;
  logic [ldsp_pkg::VAL_W-1:0] r_out_r, s_out_r;

  // A last byte needs a free result register; other bytes always proceed.
  assign proc     = in_v_r && (!last_r || !out_v_r || !out_stall);
  assign load_out = proc && last_r;
  assign in_stall = in_v_r && !proc;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_sig_byte;
      last_r <= in_last;
    end
  end

  ldsp_ctrl #(
    .MAX_SIG_BYTES(MAX_SIG_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (proc),
    .sig_byte (byte_r),
    .last     (last_r),
    .ctl      (ctl)
  );

  ldsp_value u_r_val (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (proc),
    .last     (last_r),
    .sig      (ctl.r_sig),
    .sig_byte (byte_r),
    .val_nxt  (r_nxt),
    .ovf_nxt  (r_ovf)
  );

  ldsp_value u_s_val (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (proc),
    .last     (last_r),
    .sig      (ctl.s_sig),
    .sig_byte (byte_r),
    .val_nxt  (s_nxt),
    .ovf_nxt  (s_ovf)
  );

  always_comb begin
    if (!ctl.done_ok) status_nxt = ldsp_pkg::ST_REJECT;
    else if (r_ovf || s_ovf) status_nxt = ldsp_pkg::ST_OVERFLOW;
    else status_nxt = ldsp_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load_out) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= status_nxt;
      r_out_r  <= (status_nxt == ldsp_pkg::ST_OK) ? r_nxt : '0;
      s_out_r  <= (status_nxt == ldsp_pkg::ST_OK) ? s_nxt : '0;
    end
  end

  assign out_valid   = out_v_r;
  assign out_status  = status_r;
  assign out_r_word3 = r_out_r[4*ldsp_pkg::WORD_W-1:3*ldsp_pkg::WORD_W];
  assign out_r_word2 = r_out_r[3*ldsp_pkg::WORD_W-1:2*ldsp_pkg::WORD_W];
  assign out_r_word1 = r_out_r[2*ldsp_pkg::WORD_W-1:ldsp_pkg::WORD_W];
  assign out_r_word0 = r_out_r[ldsp_pkg::WORD_W-1:0];
  assign out_s_word3 = s_out_r[4*ldsp_pkg::WORD_W-1:3*ldsp_pkg::WORD_W];
  assign out_s_word2 = s_out_r[3*ldsp_pkg::WORD_W-1:2*ldsp_pkg::WORD_W];
  assign out_s_word1 = s_out_r[2*ldsp_pkg::WORD_W-1:ldsp_pkg::WORD_W];
  assign out_s_word0 = s_out_r[ldsp_pkg::WORD_W-1:0];

endmodule

// ===== src/ldsp_checker.sv =====
// Port-level checks for the lax DER signature parser, bound to the top level.
// Depends on ldsp_pkg and lax_der_signature_parser_unit.
module ldsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [63:0] out_r_word3,
  input logic [63:0] out_r_word0,
  input logic [63:0] out_s_word3,
  input logic [63:0] out_s_word0
);

  // A rejected or overflowing signature reports zero values.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ldsp_pkg::ST_OK) |->
      (out_r_word3 == 64'd0) && (out_r_word0 == 64'd0) &&
      (out_s_word3 == 64'd0) && (out_s_word0 == 64'd0))
    else $error("nonzero value with failing status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ldsp_pkg::ST_REJECT) || (out_status == ldsp_pkg::ST_OK) ||
                  (out_status == ldsp_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // Only a last byte produces a result: each new result follows an accepted last byte or a stalled input.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid ##1 out_valid |-> $past(in_valid && !in_stall && in_last, 2) ||
                                  $past(in_stall, 1))
    else $error("result without a preceding last byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lax_der_signature_parser_unit ldsp_checker u_ldsp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_last     (in_last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_status  (out_status),
  .out_r_word3 (out_r_word3),
  .out_r_word0 (out_r_word0),
  .out_s_word3 (out_s_word3),
  .out_s_word0 (out_s_word0)
);
